[rtl/core/tlec_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlec_pkg
// Shared types, sizes and set-row update functions for the two-level
// exclusive cache model.
// ----------------------------------------------------------------------------
package tlec_pkg;

	localparam int ADDR_W     = 48;
	localparam int WAYS       = 8;
	localparam int WAY_W      = 3;
	localparam int RANK_W     = 3;
	localparam int L1_SET_W   = 6;
	localparam int L2_SET_W   = 8;
	localparam int L1_SETS    = 64;
	localparam int L2_SETS    = 256;
	localparam int OFF_W      = 4;
	localparam int CNT_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_L1_SET_BITS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_L1_LRU_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_SET_BITS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS     = 3'd5;

	typedef struct packed {
		logic [WAYS-1:0]             v;
		logic [WAYS-1:0][ADDR_W-1:0] a;
		logic [WAYS-1:0][RANK_W-1:0] r;
	} row_t;

	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] way;
	} find_t;

	typedef struct packed {
		row_t              row;
		logic              evict;
		logic [ADDR_W-1:0] old;
	} place_t;

	function automatic logic [WAYS-1:0] way_mask(logic [CNT_W-1:0] n);
		logic [WAYS-1:0] m;
		for (int i = 0; i < WAYS; i++) begin
			m[i] = (CNT_W'(i) < n);
		end
		return m;
	endfunction

	function automatic row_t order_remove(row_t row, logic [WAYS-1:0] act,
			logic [WAY_W-1:0] w);
		row_t o;
		o = row;
		for (int i = 0; i < WAYS; i++) begin
			if (WAY_W'(i) != w && act[i] && row.v[i] && row.r[i] > row.r[w]) begin
				o.r[i] = row.r[i] - RANK_W'(1);
			end
		end
		return o;
	endfunction

	function automatic row_t order_top(row_t row, logic [WAYS-1:0] act,
			logic [WAY_W-1:0] w);
		row_t o;
		logic [RANK_W-1:0] c;
		o = row;
		c = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (WAY_W'(i) != w && act[i] && row.v[i]) begin
				c = c + RANK_W'(1);
			end
		end
		o.r[w] = c;
		return o;
	endfunction

	function automatic find_t find_way(row_t row, logic [WAYS-1:0] act,
			logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] tmask);
		find_t f;
		f = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (act[i] && row.v[i] && (((row.a[i] ^ addr) & tmask) == '0)) begin
				f.hit = 1'b1;
				f.way = WAY_W'(i);
			end
		end
		return f;
	endfunction

	function automatic place_t place_line(row_t row, logic [WAYS-1:0] act,
			logic [ADDR_W-1:0] addr);
		place_t p;
		logic free_found;
		logic old_found;
		logic [WAY_W-1:0] fw;
		logic [WAY_W-1:0] ow;
		free_found = 1'b0;
		old_found = 1'b0;
		fw = '0;
		ow = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (act[i] && !row.v[i]) begin
				free_found = 1'b1;
				fw = WAY_W'(i);
			end
		end
		for (int i = 0; i < WAYS; i++) begin
			if (act[i] && row.v[i] && (!old_found || row.r[i] < row.r[ow])) begin
				old_found = 1'b1;
				ow = WAY_W'(i);
			end
		end
		p.row = row;
		p.evict = 1'b0;
		p.old = row.a[ow];
		if (free_found) begin
			p.row.v[fw] = 1'b1;
			p.row.a[fw] = addr;
			p.row = order_top(p.row, act, fw);
		end else begin
			p.evict = 1'b1;
			p.row = order_remove(p.row, act, ow);
			p.row.a[ow] = addr;
			p.row = order_top(p.row, act, ow);
		end
		return p;
	endfunction

endpackage
`default_nettype wire

[rtl/core/two_level_exclusive_cache_model_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_exclusive_cache_model_top
// L1 set-associative cache with an exclusive L2 victim cache; one access per
// beat, one result beat of hit and memory traffic flags per access.
// ----------------------------------------------------------------------------
// Channel  Signals                                        Direction
// in       in_valid, in_ready, op, address                 into block
// out      out_valid, out_ready, l1_hit, l2_hit,
//          mem_read, mem_write                             out of block
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data       into block
//
// Each access is a read-modify-write of one set row per memory (S_RD, S_EV),
// plus one of the victim's L2 row (S_RD2, S_EV2) when an L1 line is evicted.
// Each set row holds all ways of a set; a row not yet written since reset
// reads as empty through a per-row valid flag, so no clearing pass is needed.
// The next input beat is taken once the previous result sits in the output
// register; a stalled output holds the block after its work is done.
// ----------------------------------------------------------------------------
module two_level_exclusive_cache_model_top
	import tlec_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  op,
	input  wire logic [ADDR_W-1:0]     address,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       l1_hit,
	output logic                       l2_hit,
	output logic                       mem_read,
	output logic                       mem_write,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_EV   = 6'b000100,
		S_RD2  = 6'b001000,
		S_EV2  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;

	logic [OFF_W-1:0] offset_bits_q;
	logic [2:0]       l1_set_bits_q;
	logic [CNT_W-1:0] l1_ways_q;
	logic             l1_lru_mode_q;
	logic [3:0]       l2_set_bits_q;
	logic [CNT_W-1:0] l2_ways_q;

	logic              op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] victim_q;
	logic              h1_q;
	logic              h2_q;

	row_t l1_mem [L1_SETS];
	row_t l2_mem [L2_SETS];
	row_t l1_rd_q;
	row_t l2_rd_q;
	logic l1_rd_ok_q;
	logic l2_rd_ok_q;
	logic [L1_SETS-1:0] l1_row_vld_q;
	logic [L2_SETS-1:0] l2_row_vld_q;

	logic [2:0] sb1;
	logic [3:0] sb2;
	logic [WAYS-1:0] act1;
	logic [WAYS-1:0] act2;
	logic [ADDR_W-1:0] blk;
	logic [ADDR_W-1:0] vblk;
	logic [L1_SET_W-1:0] set1;
	logic [L2_SET_W-1:0] set2;
	logic [L2_SET_W-1:0] vset;
	logic [ADDR_W-1:0] tmask1;
	logic [ADDR_W-1:0] tmask2;
	row_t l1_row;
	row_t l2_row;
	row_t l1_new;
	row_t l2_new;
	row_t l2_ev_new;
	find_t f1;
	find_t f2;
	place_t p1;
	place_t p2;
	logic [L2_SET_W-1:0] l2_raddr;
	logic [L2_SET_W-1:0] l2_waddr;
	row_t l2_wdata;
	logic l2_we;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		sb1 = (l1_set_bits_q > 3'd6) ? 3'd6 : l1_set_bits_q;
		sb2 = (l2_set_bits_q > 4'd8) ? 4'd8 : l2_set_bits_q;
		act1 = way_mask((l1_ways_q == '0) ? CNT_W'(1) :
			(l1_ways_q > CNT_W'(WAYS)) ? CNT_W'(WAYS) : l1_ways_q);
		act2 = way_mask((l2_ways_q == '0) ? CNT_W'(1) :
			(l2_ways_q > CNT_W'(WAYS)) ? CNT_W'(WAYS) : l2_ways_q);
		blk  = addr_q >> offset_bits_q;
		vblk = victim_q >> offset_bits_q;
		set1 = blk[L1_SET_W-1:0] & ~(L1_SET_W'('1) << sb1);
		set2 = blk[L2_SET_W-1:0] & ~(L2_SET_W'('1) << sb2);
		vset = vblk[L2_SET_W-1:0] & ~(L2_SET_W'('1) << sb2);
		tmask1 = ADDR_W'('1) << ({1'b0, offset_bits_q} + {2'b00, sb1});
		tmask2 = ADDR_W'('1) << ({1'b0, offset_bits_q} + {1'b0, sb2});
	end

	always_comb begin
		l1_row = l1_rd_q;
		l2_row = l2_rd_q;
		if (!l1_rd_ok_q) begin
			l1_row.v = '0;
			l1_row.r = '0;
		end
		if (!l2_rd_ok_q) begin
			l2_row.v = '0;
			l2_row.r = '0;
		end
		f1 = find_way(l1_row, act1, addr_q, tmask1);
		f2 = find_way(l2_row, act2, addr_q, tmask2);
		p1 = place_line(l1_row, act1, addr_q);
		l1_new = l1_row;
		if (!f1.hit) begin
			l1_new = p1.row;
		end else if (l1_lru_mode_q) begin
			l1_new = order_top(order_remove(l1_row, act1, f1.way), act1, f1.way);
		end
		l2_new = l2_row;
		if (f2.hit) begin
			l2_new = order_remove(l2_row, act2, f2.way);
			l2_new.v[f2.way] = 1'b0;
			l2_new.r[f2.way] = '0;
			l2_new.a[f2.way] = '0;
		end
		p2 = place_line(l2_row, act2, victim_q);
		l2_ev_new = p2.row;
	end

	always_comb begin
		l2_raddr = (state_q == S_RD2) ? vset : set2;
		l2_waddr = (state_q == S_EV2) ? vset : set2;
		l2_wdata = (state_q == S_EV2) ? l2_ev_new : l2_new;
		l2_we    = (state_q == S_EV) || (state_q == S_EV2);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD) begin
			l1_rd_q <= l1_mem[set1];
		end
		if (state_q == S_RD || state_q == S_RD2) begin
			l2_rd_q <= l2_mem[l2_raddr];
		end
		if (state_q == S_EV) begin
			l1_mem[set1] <= l1_new;
		end
		if (l2_we) begin
			l2_mem[l2_waddr] <= l2_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= op;
			addr_q <= address;
		end
		if (state_q == S_EV) begin
			h1_q     <= f1.hit;
			h2_q     <= f2.hit;
			victim_q <= p1.old;
		end
		if (state_q == S_DONE && (!out_valid || out_ready)) begin
			l1_hit    <= h1_q;
			l2_hit    <= !h1_q && h2_q;
			mem_read  <= !h1_q && !h2_q;
			mem_write <= op_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid     <= 1'b0;
			l1_row_vld_q  <= '0;
			l2_row_vld_q  <= '0;
			l1_rd_ok_q    <= 1'b0;
			l2_rd_ok_q    <= 1'b0;
			offset_bits_q <= 4'd6;
			l1_set_bits_q <= 3'd4;
			l1_ways_q     <= 4'd2;
			l1_lru_mode_q <= 1'b1;
			l2_set_bits_q <= 4'd6;
			l2_ways_q     <= 4'd4;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
					CFG_L1_SET_BITS: l1_set_bits_q <= cfg_data[2:0];
					CFG_L1_WAYS:     l1_ways_q     <= cfg_data;
					CFG_L1_LRU_MODE: l1_lru_mode_q <= cfg_data[0];
					CFG_L2_SET_BITS: l2_set_bits_q <= cfg_data;
					CFG_L2_WAYS:     l2_ways_q     <= cfg_data;
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			if (state_q == S_RD) begin
				l1_rd_ok_q <= l1_row_vld_q[set1];
			end
			if (state_q == S_RD || state_q == S_RD2) begin
				l2_rd_ok_q <= l2_row_vld_q[l2_raddr];
			end
			if (state_q == S_EV) begin
				l1_row_vld_q[set1] <= 1'b1;
			end
			if (l2_we) begin
				l2_row_vld_q[l2_waddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_EV;
				S_EV: begin
					state_q <= (!f1.hit && p1.evict) ? S_RD2 : S_DONE;
				end
				S_RD2: state_q <= S_EV2;
				S_EV2: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[bench/tb_two_level_exclusive_cache_model_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_level_exclusive_cache_model_top
// Checks the two-level exclusive cache against a behavioral copy of its L1
// and L2 set stores. Directed accesses cover hits, fills, evictions into L2,
// L2 hits and both replacement orders; random accesses run over several
// geometries with random gaps on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb_two_level_exclusive_cache_model_top;
	import tlec_pkg::*;

	typedef struct packed {
		logic l1h;
		logic l2h;
		logic mrd;
		logic mwr;
	} flags_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = 1'b0;
	logic [ADDR_W-1:0] address = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic l1_hit, l2_hit, mem_read, mem_write;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int cyc = 0;
	int errors = 0;
	int n_acc = 0;
	int n_res = 0;
	int n_cfg = 0;
	int hold_cycles = 0;
	flags_t expected_flags[$];

	// Predictor copy of the block's state and settings.
	int c_off, c_sb1, c_w1, c_lru, c_sb2, c_w2;
	bit v1[L1_SETS][WAYS];
	logic [ADDR_W-1:0] a1[L1_SETS][WAYS];
	int r1[L1_SETS][WAYS];
	bit v2[L2_SETS][WAYS];
	logic [ADDR_W-1:0] a2[L2_SETS][WAYS];
	int r2[L2_SETS][WAYS];

	always #1 clk = ~clk;
	always @(posedge clk) cyc <= cyc + 1;

	two_level_exclusive_cache_model_top u_top (.*);

	function automatic int fit_bits(int b, int max_sets);
		while (b > 0 && (1 << b) > max_sets) b--;
		return b;
	endfunction

	function automatic int fit_ways(int w);
		if (w == 0) return 1;
		if (w > WAYS) return WAYS;
		return w;
	endfunction

	function automatic logic [ADDR_W-1:0] block_of(logic [ADDR_W-1:0] a, int sh);
		return a >> sh;
	endfunction

	function automatic void age_out(ref bit v[WAYS], ref int r[WAYS], input int n,
			input int w);
		for (int i = 0; i < n; i++)
			if (i != w && v[i] && r[i] > r[w]) r[i]--;
	endfunction

	function automatic void make_newest(ref bit v[WAYS], ref int r[WAYS],
			input int n, input int w);
		int c;
		c = 0;
		for (int i = 0; i < n; i++)
			if (i != w && v[i]) c++;
		r[w] = c;
	endfunction

	function automatic bit insert_line(ref bit v[WAYS], ref logic [ADDR_W-1:0] a[WAYS],
			ref int r[WAYS], input int n, input logic [ADDR_W-1:0] addr,
			output logic [ADDR_W-1:0] old);
		int w;
		bit found;
		w = 0;
		found = 0;
		old = '0;
		for (int i = 0; i < n; i++)
			if (!v[i]) begin
				v[i] = 1;
				a[i] = addr;
				make_newest(v, r, n, i);
				return 0;
			end
		for (int i = 0; i < n; i++)
			if (v[i] && (!found || r[i] < r[w])) begin
				w = i;
				found = 1;
			end
		old = a[w];
		age_out(v, r, n, w);
		a[w] = addr;
		make_newest(v, r, n, w);
		return 1;
	endfunction

	function automatic flags_t cache_access(logic wr, logic [ADDR_W-1:0] addr);
		flags_t f;
		int sb1, sb2, n1, n2, s1, s2, vs, w;
		bit h1, h2;
		logic [ADDR_W-1:0] victim, dummy;
		sb1 = fit_bits(c_sb1, L1_SETS);
		sb2 = fit_bits(c_sb2, L2_SETS);
		n1 = fit_ways(c_w1);
		n2 = fit_ways(c_w2);
		s1 = int'((addr >> c_off) & ((48'd1 << sb1) - 1));
		s2 = int'((addr >> c_off) & ((48'd1 << sb2) - 1));
		h1 = 0;
		h2 = 0;
		w = 0;
		for (int i = n1 - 1; i >= 0; i--)
			if (v1[s1][i] && block_of(a1[s1][i], c_off + sb1) == block_of(addr, c_off + sb1))
			begin
				h1 = 1;
				w = i;
			end
		if (h1 && c_lru != 0) begin
			age_out(v1[s1], r1[s1], n1, w);
			make_newest(v1[s1], r1[s1], n1, w);
		end
		for (int i = n2 - 1; i >= 0; i--)
			if (v2[s2][i] && block_of(a2[s2][i], c_off + sb2) == block_of(addr, c_off + sb2))
			begin
				h2 = 1;
				w = i;
			end
		if (h2) begin
			age_out(v2[s2], r2[s2], n2, w);
			v2[s2][w] = 0;
			r2[s2][w] = 0;
			a2[s2][w] = '0;
		end
		if (!h1) begin
			if (insert_line(v1[s1], a1[s1], r1[s1], n1, addr, victim)) begin
				vs = int'((victim >> c_off) & ((48'd1 << sb2) - 1));
				void'(insert_line(v2[vs], a2[vs], r2[vs], n2, victim, dummy));
			end
		end
		f.l1h = h1;
		f.l2h = !h1 && h2;
		f.mrd = !h1 && !h2;
		f.mwr = wr;
		return f;
	endfunction

	task automatic wait_cycles(int n);
		repeat (n) @(negedge clk);
	endtask

	task automatic send_access(logic wr, logic [ADDR_W-1:0] addr, bit gaps = 1);
		if (gaps && $urandom_range(0, 2) != 0) wait_cycles($urandom_range(0, 10));
		@(negedge clk);
		in_valid <= 1'b1;
		op <= wr;
		address <= addr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_flags.push_back(cache_access(wr, addr));
		n_acc++;
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (expected_flags.size() != 0) @(negedge clk);
		wait_cycles(12);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_OFFSET_BITS: c_off = val & 15;
			CFG_L1_SET_BITS: c_sb1 = val & 7;
			CFG_L1_WAYS:     c_w1 = val & 15;
			CFG_L1_LRU_MODE: c_lru = val & 1;
			CFG_L2_SET_BITS: c_sb2 = val & 15;
			CFG_L2_WAYS:     c_w2 = val & 15;
			default: ;
		endcase
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_geometry(int off, int sb1, int w1, int lru, int sb2, int w2);
		drain();
		write_reg(CFG_OFFSET_BITS, off);
		write_reg(CFG_L1_SET_BITS, sb1);
		write_reg(CFG_L1_WAYS, w1);
		write_reg(CFG_L1_LRU_MODE, lru);
		write_reg(CFG_L2_SET_BITS, sb2);
		write_reg(CFG_L2_WAYS, w2);
	endtask

	function automatic logic [ADDR_W-1:0] rand_addr();
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	// Addresses drawn from a small pool of blocks so sets fill and lines return.
	function automatic logic [ADDR_W-1:0] pool_addr(int blocks);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'($urandom_range(0, blocks - 1)) << c_off;
		a = a | (ADDR_W'($urandom()) & ((48'd1 << c_off) - 1));
		if ($urandom_range(0, 7) == 0) a = a ^ (48'h8000_0000_0000 >> $urandom_range(0, 3));
		return a;
	endfunction

	// Result checker with random stalls and one long hold-off.
	always @(posedge clk) begin
		flags_t e;
		if (out_valid && out_ready) begin
			n_res++;
			if (expected_flags.size() == 0) begin
				$display("%0t: result beat with no access outstanding: %b%b%b%b", $time,
					l1_hit, l2_hit, mem_read, mem_write);
				errors++;
			end else begin
				e = expected_flags.pop_front();
				if (e.l1h !== l1_hit) begin
					$display("%0t: l1_hit expected %b actual %b", $time, e.l1h, l1_hit);
					errors++;
				end
				if (e.l2h !== l2_hit) begin
					$display("%0t: l2_hit expected %b actual %b", $time, e.l2h, l2_hit);
					errors++;
				end
				if (e.mrd !== mem_read) begin
					$display("%0t: mem_read expected %b actual %b", $time, e.mrd, mem_read);
					errors++;
				end
				if (e.mwr !== mem_write) begin
					$display("%0t: mem_write expected %b actual %b", $time, e.mwr, mem_write);
					errors++;
				end
			end
		end
	end

	int stall_left = 0;
	bit steady = 0;
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else if (steady) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (out_valid && out_ready && $urandom_range(0, 1)) stall_left <= $urandom_range(0, 10);
		end
	end

	task automatic test_directed();
		logic [ADDR_W-1:0] b;
		b = 48'h0000_0000_1000;
		set_geometry(6, 0, 2, 1, 0, 2);
		send_access(1'b0, 48'h0);
		send_access(1'b1, 48'h3f);
		send_access(1'b0, 48'hFFFF_FFFF_FFFF);
		send_access(1'b1, b);
		send_access(1'b0, 48'h0);
		send_access(1'b0, b + 48'h40);
		send_access(1'b0, 48'hFFFF_FFFF_FFC0);
		send_access(1'b1, b);
		send_access(1'b0, 48'h0);
		send_access(1'b0, b + 48'h80);
		send_access(1'b0, b + 48'hC0);
		set_geometry(6, 0, 2, 0, 0, 2);
		send_access(1'b0, 48'h100);
		send_access(1'b0, 48'h140);
		send_access(1'b0, 48'h100);
		send_access(1'b0, 48'h180);
		send_access(1'b0, 48'h100);
		send_access(1'b0, 48'h140);
		set_geometry(12, 7, 0, 1, 15, 15);
		send_access(1'b1, 48'hAAAA_AAAA_AAAA);
		send_access(1'b0, 48'h5555_5555_5555);
		send_access(1'b0, 48'hAAAA_AAAA_AAAA);
		send_access(1'b1, 48'hAAAA_AAAA_A000 ^ 48'h0040_0000_0000);
		send_access(1'b0, 48'hAAAA_AAAA_AAAA);
	endtask

	task automatic test_random(int count, int blocks);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0) send_access(1'($urandom_range(0, 1)), rand_addr());
			else send_access(1'($urandom_range(0, 1)), pool_addr(blocks));
		end
	endtask

	task automatic test_backpressure();
		drain();
		steady = 1;
		hold_cycles = 200;
		for (int i = 0; i < 12; i++) send_access(1'($urandom_range(0, 1)), pool_addr(8), 0);
		drain();
		for (int i = 0; i < 30; i++) send_access(1'($urandom_range(0, 1)), pool_addr(12), 0);
		steady = 0;
		drain();
	endtask

	initial begin
		c_off = 6; c_sb1 = 4; c_w1 = 2; c_lru = 1; c_sb2 = 6; c_w2 = 4;
		foreach (v1[s, w]) begin v1[s][w] = 0; a1[s][w] = '0; r1[s][w] = 0; end
		foreach (v2[s, w]) begin v2[s][w] = 0; a2[s][w] = '0; r2[s][w] = 0; end
		wait_cycles(3);
		arst_n = 1'b1;
		test_random(40, 64);
		test_directed();
		set_geometry(6, 4, 2, 1, 6, 4);
		test_random(90, 200);
		set_geometry(0, 0, 1, 0, 0, 1);
		test_random(60, 6);
		set_geometry(4, 1, 3, 1, 2, 2);
		test_random(90, 24);
		test_backpressure();
		set_geometry(12, 6, 8, 0, 8, 8);
		test_random(80, 600);
		set_geometry(3, 2, 4, 0, 1, 3);
		test_random(100, 40);
		set_geometry(6, 4, 2, 1, 6, 4);
		test_random(40, 30);
		drain();
		$display("Covered %0d accesses with %0d results over %0d register writes,",
			n_acc, n_res, n_cfg);
		$display("including fills, L1/L2 hits, victim eviction and a long output stall.");
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		wait (cyc == 400000);
		$display("Timed out with %0d results outstanding.", expected_flags.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
